// ===== src/ssrs_pkg.sv =====
// Shared types, codes and constants of the SMS send retry sequencer.
package ssrs_pkg;

   // Millisecond timer width and its saturation value
   localparam int TIMER_BITS = 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Configuration register file
   localparam int CFG_BITS       = 16;
   localparam int CFG_INDEX_BITS = 2;
   localparam int RETRY_BITS     = 3;
   localparam int COUNT_BITS     = 4;

   localparam logic [CFG_INDEX_BITS-1:0] CSR_PROMPT_TIMEOUT   = 2'd0;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_RESPONSE_TIMEOUT = 2'd1;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_MAX_RETRIES      = 2'd2;

   localparam logic [CFG_BITS-1:0]   PROMPT_TIMEOUT_RESET   = 16'd5000;
   localparam logic [CFG_BITS-1:0]   RESPONSE_TIMEOUT_RESET = 16'd12000;
   localparam logic [RETRY_BITS-1:0] MAX_RETRIES_RESET      = 3'd3;

   // Queue between the classifier and the sequencer
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Item kinds
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_EVENT   = 2'd1;
   localparam logic [1:0] OP_REQUEST = 2'd2;

   // Modem events
   localparam logic [2:0] EV_OK      = 3'd0;
   localparam logic [2:0] EV_PROMPT  = 3'd1;
   localparam logic [2:0] EV_ERROR   = 3'd2;
   localparam logic [2:0] EV_CMS     = 3'd3;
   localparam logic [2:0] EV_CONFIRM = 3'd4;

   // Action codes
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_NUMBER = 3'd1;
   localparam logic [2:0] ACT_TEXT   = 3'd2;
   localparam logic [2:0] ACT_SENT   = 3'd3;
   localparam logic [2:0] ACT_FAIL   = 3'd4;

   // Phases
   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_PROMPT = 2'd1,
      PHASE_RESULT = 2'd2
   } phase_type;

   // Classified commands handed from front to back
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_REQUEST,
      CMD_PROMPT,
      CMD_FAULT,
      CMD_DONE
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] event_kind;
   } req_type;

   typedef struct packed {
      logic [2:0]            action;
      logic [1:0]            phase_now;
      logic [COUNT_BITS-1:0] retries_used;
   } rsp_type;

   // Handshake bundle for one command transaction
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_xfer_type;

   // Timeout register clamped to the timer range
   function automatic logic [TIMER_BITS-1:0] clamp_limit(input logic [CFG_BITS-1:0] t);
      logic [32:0] wide;
      wide = 33'(t);
      if (wide > 33'(TIMER_MAX)) begin
         return TIMER_MAX;
      end
      return wide[TIMER_BITS-1:0];
   endfunction

endpackage

// ===== src/ssrs_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
module ssrs_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssrs_pkg::req_type     req,
   output ssrs_pkg::cmd_xfer_type push,
   input  logic                  push_ready
);
   import ssrs_pkg::*;

   cmd_type cmd;

   // Decode item kind and event into one command
   always_comb begin
      cmd = CMD_NONE;
      unique case (req.op)
         OP_TICK:    cmd = CMD_TICK;
         OP_REQUEST: cmd = CMD_REQUEST;
         OP_EVENT: begin
            case (req.event_kind) inside
               EV_PROMPT:            cmd = CMD_PROMPT;
               EV_ERROR, EV_CMS:     cmd = CMD_FAULT;
               EV_OK, EV_CONFIRM:    cmd = CMD_DONE;
               default:              cmd = CMD_NONE;
            endcase
         end
         default: cmd = CMD_NONE;
      endcase
   end

   assign req_ready  = push_ready;
   assign push.valid = req_valid;
   assign push.cmd   = cmd;

endmodule

// ===== src/ssrs_queue.sv =====
// Short command queue that decouples the classifier from the sequencer.
module ssrs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ssrs_pkg::cmd_xfer_type push,
   output logic                   push_ready,
   output ssrs_pkg::cmd_xfer_type head,
   input  logic                   pop_ready
);
   import ssrs_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   function automatic logic [QUEUE_PTR_BITS-1:0] bump(input logic [QUEUE_PTR_BITS-1:0] p);
      if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid & push_ready;
   assign do_pop     = head.valid & pop_ready;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== src/ssrs_back.sv =====
// Back end: phase sequencer, timer, retry count, config registers, result register.
module ssrs_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssrs_pkg::cmd_xfer_type                head,
   output logic                                  pop_ready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ssrs_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [ssrs_pkg::CFG_BITS-1:0]         csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ssrs_pkg::rsp_type                     rsp
);
   import ssrs_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] retry_ff, retry_in;
   logic [CFG_BITS-1:0]   prompt_to_ff, response_to_ff;
   logic [RETRY_BITS-1:0] max_retries_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;

   logic                  step;
   logic                  busy;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [TIMER_BITS-1:0] limit;
   logic                  do_retry;
   logic [COUNT_BITS-1:0] retry_next;
   logic                  give_up;
   logic                  enter_phase;
   logic [2:0]            action;

   // Take a command when the result register is free or being drained
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign step      = head.valid & pop_ready;
   assign csr_ready = 1'b1;

   // Shared step terms
   always_comb begin
      busy        = (phase_ff != PHASE_IDLE);
      elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      limit       = clamp_limit((phase_ff == PHASE_PROMPT) ? prompt_to_ff : response_to_ff);
      retry_next  = retry_ff + 1'b1;
      give_up     = (retry_next > {1'b0, max_retries_ff});
      do_retry    = busy && ((head.cmd == CMD_FAULT) ||
                             ((head.cmd == CMD_TICK) && (elapsed_inc >= limit)));
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PHASE_IDLE: begin
               if (head.cmd == CMD_REQUEST) phase_in = PHASE_PROMPT;
            end
            PHASE_PROMPT: begin
               if (head.cmd == CMD_PROMPT)  phase_in = PHASE_RESULT;
               else if (do_retry)           phase_in = give_up ? PHASE_IDLE : PHASE_PROMPT;
            end
            PHASE_RESULT: begin
               if (head.cmd == CMD_DONE)    phase_in = PHASE_IDLE;
               else if (do_retry)           phase_in = give_up ? PHASE_IDLE : PHASE_PROMPT;
            end
            default: phase_in = PHASE_IDLE;
         endcase
      end
   end

   // Action, retry count and timer per phase
   always_comb begin
      action      = ACT_NONE;
      enter_phase = 1'b0;
      retry_in    = retry_ff;
      unique case (phase_ff)
         PHASE_IDLE: begin
            if (head.cmd == CMD_REQUEST) begin
               action      = ACT_NUMBER;
               enter_phase = 1'b1;
               retry_in    = '0;
            end
         end
         PHASE_PROMPT, PHASE_RESULT: begin
            if (phase_ff == PHASE_PROMPT && head.cmd == CMD_PROMPT) begin
               action      = ACT_TEXT;
               enter_phase = 1'b1;
            end else if (phase_ff == PHASE_RESULT && head.cmd == CMD_DONE) begin
               action      = ACT_SENT;
               enter_phase = 1'b1;
               retry_in    = '0;
            end else if (do_retry) begin
               action      = give_up ? ACT_FAIL : ACT_NUMBER;
               enter_phase = 1'b1;
               retry_in    = give_up ? '0 : retry_next;
            end
         end
         default: action = ACT_NONE;
      endcase
      if (enter_phase) begin
         elapsed_in = '0;
      end else if (busy && head.cmd == CMD_TICK) begin
         elapsed_in = elapsed_inc;
      end else begin
         elapsed_in = elapsed_ff;
      end
      rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         elapsed_ff   <= '0;
         retry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            elapsed_ff <= elapsed_in;
            retry_ff   <= retry_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff.action       <= action;
         rsp_ff.phase_now    <= phase_in;
         rsp_ff.retries_used <= retry_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_to_ff   <= PROMPT_TIMEOUT_RESET;
         response_to_ff <= RESPONSE_TIMEOUT_RESET;
         max_retries_ff <= MAX_RETRIES_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROMPT_TIMEOUT:   prompt_to_ff   <= csr_data;
            CSR_RESPONSE_TIMEOUT: response_to_ff <= csr_data;
            CSR_MAX_RETRIES:      max_retries_ff <= csr_data[RETRY_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/sms_send_retry_sequencer.sv =====
// Top level of the SMS send retry sequencer: classifier, command queue, sequencer.
//
// Each req transaction (millisecond tick, modem event or send request) yields
// exactly one rsp transaction carrying the action, the phase after the step
// and the retry count. A new item is taken every cycle while the queue has
// room; each item passes through the command queue and then the result
// register of the sequencer, which updates phase, timer and retry count once
// per item. A two-entry queue between classifier and sequencer absorbs
// rsp stalls, so with rsp stalled req_ready falls once three items are held
// back, one in the result register and two in the queue. Configuration writes
// are always taken and must be issued while no transaction is in flight.
module sms_send_retry_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ssrs_pkg::req_type                   req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ssrs_pkg::rsp_type                   rsp,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssrs_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [ssrs_pkg::CFG_BITS-1:0]       csr_data
);
   import ssrs_pkg::*;

   cmd_xfer_type push, head;
   logic         push_ready, pop_ready;

   ssrs_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .push       (push),
      .push_ready (push_ready)
   );

   ssrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop_ready  (pop_ready)
   );

   ssrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop_ready (pop_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

// ===== src/ssrs_checker.sv =====
// Port-level checker of the SMS send retry sequencer and its bind.
module ssrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ssrs_pkg::rsp_type rsp
);
   import ssrs_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp changed while stalled");

   // Completion and failure both return to idle with the count cleared
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.action == ACT_SENT || rsp.action == ACT_FAIL)
      |-> rsp.phase_now == PHASE_IDLE && rsp.retries_used == '0)
      else $error("send ended without returning to idle");

   // Number command always leads into the prompt wait
   a_number_prompt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.action == ACT_NUMBER |-> rsp.phase_now == PHASE_PROMPT)
      else $error("number command outside prompt wait");

   // Message text always leads into the result wait
   a_text_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.action == ACT_TEXT |-> rsp.phase_now == PHASE_RESULT)
      else $error("message text outside result wait");

endmodule

bind sms_send_retry_sequencer ssrs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
